[src/nbgs_pkg.sv]
// ----------------------------------------------------------------------------
// nbgs_pkg: shared types and constants for the 2-D gravity step block
// Item layouts, function codes, register indexes, datapath operation codes
// and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package nbgs_pkg;

  // Default body capacity.
  localparam int MAX_POINTS_DEF = 256;

  // Largest weight and the merge distance after reset (1.0 in Q16.16).
  localparam logic [30:0] WMAX       = 31'h7FFF_FFFF;
  localparam logic [30:0] THR_RESET  = 31'd65536;
  // Upper bound of a unit-direction component (2.0 in Q16.16).
  localparam logic [17:0] U_MAX      = 18'h2_0000;
  // Width of the acceleration accumulators.
  localparam int          ACC_W      = 48;

  // Input function codes.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_STEP = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Result kinds.
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_POINT_COUNT = 2'd0;
  localparam logic [1:0] REG_SLICE_START = 2'd1;
  localparam logic [1:0] REG_SLICE_COUNT = 2'd2;
  localparam logic [1:0] REG_DIST_THR    = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         body_index;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic [30:0]        in_weight;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         out_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [30:0]        out_weight;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_IN,
    OP_RD,
    OP_LAT_I,
    OP_DIFF,
    OP_SQX,
    OP_SQY,
    OP_SQRT,
    OP_DIST,
    OP_MUL,
    OP_MERGE,
    OP_DIV_Q,
    OP_LAT_Q,
    OP_DIV_A,
    OP_LAT_A,
    OP_DIV_UX,
    OP_DIV_UY,
    OP_LAT_U,
    OP_MULC,
    OP_ACC_X,
    OP_ACC_Y,
    OP_WB,
    OP_POS,
    OP_OUT_RD,
    OP_OUT_ST
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   i_lt_j;   // current body index below partner index
  } cmd_t;

  typedef struct packed {
    logic rd_w_zero;  // weight just read is zero
    logic near;       // distance below the merge threshold
    logic d_zero;     // distance is zero
    logic sqrt_done;
    logic div_done;
    logic out_free;   // result register can take a new item
  } sts_t;

  // Saturate a 49-bit two's complement value to signed 32 bits.
  function automatic logic [31:0] sat32(input logic [48:0] v);
    logic [31:0] r;
    if (v[48] && !(&v[47:31])) begin
      r = 32'h8000_0000;
    end else if (!v[48] && (|v[47:31])) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[src/nbgs_div.sv]
// ----------------------------------------------------------------------------
// nbgs_div: iterative unsigned divider
// Restoring division of a 64-bit dividend by a 34-bit divisor, one quotient
// bit per cycle; done pulses for one cycle once the last quotient bit is in.
// ----------------------------------------------------------------------------
module nbgs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [33:0] divisor,
  output logic        done,
  output logic [63:0] quot
);

  logic [34:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [33:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [34:0] trial;

  // One restoring step per cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[33:0], quo_r[63]};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (&cnt_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

[src/nbgs_isqrt.sv]
// ----------------------------------------------------------------------------
// nbgs_isqrt: iterative integer square root
// Digit-by-digit root of a 63-bit value, two radicand bits per cycle;
// done pulses for one cycle once the last root bit is in.
// ----------------------------------------------------------------------------
module nbgs_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [62:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad_r, rad_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [34:0] part;
  logic [34:0] trial;

  // Bring down two bits and try the next root bit.
  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    part     = {rem_r[32:0], rad_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    if (start) begin
      rad_nxt  = {1'b0, radicand};
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      if (part >= trial) begin
        rem_nxt  = 34'(part - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = part[33:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (&cnt_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/nbgs_dpath.sv]
// ----------------------------------------------------------------------------
// nbgs_dpath: body store and pair arithmetic
// Holds the body memories, the pair registers, the shared divider and square
// root units, the accumulators and the result register.
// ----------------------------------------------------------------------------
module nbgs_dpath #(
  parameter int MAX_POINTS = nbgs_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nbgs_pkg::cmd_t                cmd,
  input  logic [$clog2(MAX_POINTS)-1:0] addr,
  input  nbgs_pkg::in_item_t            in_item,
  input  logic [30:0]                   thr,
  output nbgs_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nbgs_pkg::out_item_t           out_item
);
  import nbgs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  // Body memories.
  logic [31:0] mem_x  [MAX_POINTS];
  logic [31:0] mem_y  [MAX_POINTS];
  logic [30:0] mem_w  [MAX_POINTS];
  logic [31:0] mem_vx [MAX_POINTS];
  logic [31:0] mem_vy [MAX_POINTS];

  logic [31:0] rd_x_r, rd_y_r, rd_vx_r, rd_vy_r;
  logic [30:0] rd_w_r;

  logic [AW-1:0] mem_addr;
  logic          in_ok;
  logic          is_load;
  logic          we_x, we_w, we_v, rd_en;
  logic [31:0]   wd_x, wd_y, wd_vx, wd_vy;
  logic [30:0]   wd_w;

  // Body i and pair registers.
  logic [31:0] xi_r, yi_r, vxi_r, vyi_r;
  logic [30:0] wi_r, wj_r;
  logic [32:0] adx_r, ady_r;
  logic        negx_r, negy_r, sh_r;
  logic [61:0] sqx_r, sqy_r;
  logic [33:0] d_r;
  logic [46:0] q_r;
  logic [30:0] acc_r;
  logic [17:0] u_r;
  logic [48:0] prod_r;
  logic [61:0] wprod_r;
  logic [ACC_W-1:0] ax_r, ay_r;
  logic [7:0]  idx_r;
  logic        ok_r;

  logic [32:0] dx, dy, adx, ady;
  logic [30:0] sx;
  logic        sh;
  logic [30:0] mval;
  logic        absorb_i;
  logic [32:0] cterm;
  logic [31:0] vx_new, vy_new, x_new, y_new;

  // Shared units.
  logic        div_start, div_done;
  logic [63:0] div_dvd, div_quot;
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;

  logic        out_valid_r;
  out_item_t   out_item_r;

  assign is_load  = (cmd.op == OP_LOAD);
  assign in_ok    = ({24'd0, in_item.body_index} < 32'(MAX_POINTS));
  assign mem_addr = (is_load || cmd.op == OP_RD_IN) ? AW'(in_item.body_index) : addr;
  assign rd_en    = (cmd.op == OP_RD_IN) || (cmd.op == OP_RD);
  assign we_x     = (is_load && in_ok) || (cmd.op == OP_POS);
  assign we_w     = (is_load && in_ok) || (cmd.op == OP_MERGE) || (cmd.op == OP_WB);
  assign we_v     = (is_load && in_ok) || (cmd.op == OP_WB);

  // Merge: saturated weight product and the winner of the pair.
  assign mval     = (wprod_r[61:16] > 46'(WMAX)) ? WMAX : wprod_r[46:16];
  assign absorb_i = (wi_r > wj_r) || ((wi_r == wj_r) && cmd.i_lt_j);

  // Velocity and position updates with saturation.
  assign vx_new = sat32({{17{vxi_r[31]}}, vxi_r} + {ax_r[ACC_W-1], ax_r});
  assign vy_new = sat32({{17{vyi_r[31]}}, vyi_r} + {ay_r[ACC_W-1], ay_r});
  assign x_new  = sat32({{17{xi_r[31]}}, xi_r} + {{17{vxi_r[31]}}, vxi_r});
  assign y_new  = sat32({{17{yi_r[31]}}, yi_r} + {{17{vyi_r[31]}}, vyi_r});

  assign wd_x  = is_load ? in_item.in_x : x_new;
  assign wd_y  = is_load ? in_item.in_y : y_new;
  assign wd_w  = is_load ? in_item.in_weight : ((cmd.op == OP_MERGE) ?
                 (absorb_i ? 31'd0 : mval) : wi_r);
  assign wd_vx = is_load ? 32'd0 : vx_new;
  assign wd_vy = is_load ? 32'd0 : vy_new;

  // Memory ports: one access per cycle, registered read data.
  always_ff @(posedge clk) begin
    if (we_x) begin
      mem_x[mem_addr] <= wd_x;
      mem_y[mem_addr] <= wd_y;
    end
    if (we_w) begin
      mem_w[mem_addr] <= wd_w;
    end
    if (we_v) begin
      mem_vx[mem_addr] <= wd_vx;
      mem_vy[mem_addr] <= wd_vy;
    end
    if (rd_en) begin
      rd_x_r  <= mem_x[mem_addr];
      rd_y_r  <= mem_y[mem_addr];
      rd_w_r  <= mem_w[mem_addr];
      rd_vx_r <= mem_vx[mem_addr];
      rd_vy_r <= mem_vy[mem_addr];
    end
  end

  // Exact differences, magnitudes and the shared pre-shift.
  assign dx  = {rd_x_r[31], rd_x_r} - {xi_r[31], xi_r};
  assign dy  = {rd_y_r[31], rd_y_r} - {yi_r[31], yi_r};
  assign adx = dx[32] ? (33'd0 - dx) : dx;
  assign ady = dy[32] ? (33'd0 - dy) : dy;
  assign sh  = (|adx[32:31]) || (|ady[32:31]);
  assign sx  = sh_r ? (cmd.op == OP_SQX ? adx_r[32:2] : ady_r[32:2])
                    : (cmd.op == OP_SQX ? adx_r[30:0] : ady_r[30:0]);
  assign cterm = prod_r[48:16];

  // Divider operand selection.
  always_comb begin
    case (cmd.op)
      OP_DIV_Q:  div_dvd = {17'd0, wj_r, 16'd0};
      OP_DIV_A:  div_dvd = {1'b0, q_r, 16'd0};
      OP_DIV_UX: div_dvd = {15'd0, adx_r, 16'd0};
      OP_DIV_UY: div_dvd = {15'd0, ady_r, 16'd0};
      default:   div_dvd = '0;
    endcase
  end
  assign div_start  = (cmd.op == OP_DIV_Q) || (cmd.op == OP_DIV_A) ||
                      (cmd.op == OP_DIV_UX) || (cmd.op == OP_DIV_UY);
  assign sqrt_start = (cmd.op == OP_SQRT);

  nbgs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  nbgs_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (63'(sqx_r) + 63'(sqy_r)),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Pair and accumulator registers, one operation per cycle.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_RD_IN: begin
        idx_r <= in_item.body_index;
        ok_r  <= in_ok;
      end
      OP_LAT_I: begin
        xi_r  <= rd_x_r;
        yi_r  <= rd_y_r;
        wi_r  <= rd_w_r;
        vxi_r <= rd_vx_r;
        vyi_r <= rd_vy_r;
        ax_r  <= '0;
        ay_r  <= '0;
      end
      OP_DIFF: begin
        adx_r  <= adx;
        ady_r  <= ady;
        negx_r <= dx[32];
        negy_r <= dy[32];
        sh_r   <= sh;
        wj_r   <= rd_w_r;
      end
      OP_SQX:   sqx_r <= sx * sx;
      OP_SQY:   sqy_r <= sx * sx;
      OP_DIST:  d_r   <= sh_r ? {sqrt_root, 2'b00} : {2'b00, sqrt_root};
      OP_MUL:   wprod_r <= wi_r * wj_r;
      OP_MERGE: wi_r  <= absorb_i ? mval : 31'd0;
      OP_LAT_Q: q_r   <= div_quot[46:0];
      OP_LAT_A: acc_r <= (div_quot > 64'(WMAX)) ? WMAX : div_quot[30:0];
      OP_LAT_U: u_r   <= (div_quot > 64'(U_MAX)) ? U_MAX : div_quot[17:0];
      OP_MULC:  prod_r <= u_r * acc_r;
      OP_ACC_X: ax_r  <= negx_r ? ax_r - ACC_W'(cterm) : ax_r + ACC_W'(cterm);
      OP_ACC_Y: ay_r  <= negy_r ? ay_r - ACC_W'(cterm) : ay_r + ACC_W'(cterm);
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT_RD || cmd.op == OP_OUT_ST) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_RD) begin
      out_item_r.kind       <= KIND_READ;
      out_item_r.out_index  <= idx_r;
      out_item_r.out_x      <= ok_r ? rd_x_r : 32'd0;
      out_item_r.out_y      <= ok_r ? rd_y_r : 32'd0;
      out_item_r.out_weight <= ok_r ? rd_w_r : 31'd0;
    end else if (cmd.op == OP_OUT_ST) begin
      out_item_r <= '{kind: KIND_STEP, default: '0};
    end
  end

  assign sts.rd_w_zero = (rd_w_r == 31'd0);
  assign sts.near      = (d_r < {3'd0, thr});
  assign sts.d_zero    = (d_r == 34'd0);
  assign sts.sqrt_done = sqrt_done;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[src/nbgs_ctrl.sv]
// ----------------------------------------------------------------------------
// nbgs_ctrl: sequencer for loads, reads and iteration steps
// Walks the slice and the partner bodies and issues one datapath operation
// per cycle, waiting on the divider and square root units and on a free result register.
// ----------------------------------------------------------------------------
module nbgs_ctrl #(
  parameter int MAX_POINTS = nbgs_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [8:0]                    point_count,
  input  logic [7:0]                    slice_start,
  input  logic [8:0]                    slice_count,
  input  nbgs_pkg::sts_t                sts,
  output nbgs_pkg::cmd_t                cmd,
  output logic [$clog2(MAX_POINTS)-1:0] addr
);
  import nbgs_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;
  localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

  typedef enum logic [30:0] {
    S_IDLE   = 31'h0000_0001,
    S_RES_RD = 31'h0000_0002,
    S_INIT   = 31'h0000_0004,
    S_I_CHK  = 31'h0000_0008,
    S_I_LAT  = 31'h0000_0010,
    S_J_CHK  = 31'h0000_0020,
    S_J_LAT  = 31'h0000_0040,
    S_SQX    = 31'h0000_0080,
    S_SQY    = 31'h0000_0100,
    S_SQRT   = 31'h0000_0200,
    S_SQRT_W = 31'h0000_0400,
    S_TEST   = 31'h0000_0800,
    S_MUL    = 31'h0000_1000,
    S_MRG    = 31'h0000_2000,
    S_DQ     = 31'h0000_4000,
    S_DQ_W   = 31'h0000_8000,
    S_DA     = 31'h0001_0000,
    S_DA_W   = 31'h0002_0000,
    S_DUX    = 31'h0004_0000,
    S_DUX_W  = 31'h0008_0000,
    S_MX     = 31'h0010_0000,
    S_AX     = 31'h0020_0000,
    S_DUY    = 31'h0040_0000,
    S_DUY_W  = 31'h0080_0000,
    S_MY     = 31'h0100_0000,
    S_AY     = 31'h0200_0000,
    S_WB     = 31'h0400_0000,
    S_P_CHK  = 31'h0800_0000,
    S_P_LAT  = 31'h1000_0000,
    S_P_WR   = 31'h2000_0000,
    S_RES_ST = 31'h4000_0000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, end_r, end_nxt, n_r, n_nxt;
  logic [CW-1:0] sum_end;

  assign sum_end  = CW'(slice_start) + CW'(slice_count);
  assign addr     = (state_r == S_J_CHK || state_r == S_MRG) ? j_r[AW-1:0] : i_r[AW-1:0];
  assign in_ready = (state_r == S_IDLE);

  // Next state and the operation issued in this cycle.
  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    end_nxt    = end_r;
    n_nxt      = n_r;
    cmd.op     = OP_NONE;
    cmd.i_lt_j = (i_r < j_r);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_LOAD: cmd.op = OP_LOAD;
            FUNC_READ: begin
              cmd.op    = OP_RD_IN;
              state_nxt = S_RES_RD;
            end
            FUNC_STEP: state_nxt = S_INIT;
            default: ;
          endcase
        end
      end
      S_RES_RD: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT_RD;
          state_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        i_nxt     = CW'(slice_start);
        end_nxt   = (sum_end > MAXC) ? MAXC : sum_end;
        n_nxt     = (CW'(point_count) > MAXC) ? MAXC : CW'(point_count);
        state_nxt = S_I_CHK;
      end
      S_I_CHK: begin
        if (i_r >= end_r) begin
          i_nxt     = CW'(slice_start);
          state_nxt = S_P_CHK;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_I_LAT;
        end
      end
      S_I_LAT: begin
        cmd.op = OP_LAT_I;
        if (sts.rd_w_zero) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_I_CHK;
        end else begin
          j_nxt     = '0;
          state_nxt = S_J_CHK;
        end
      end
      S_J_CHK: begin
        if (j_r >= n_r) begin
          state_nxt = S_WB;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_J_LAT;
        end
      end
      S_J_LAT: begin
        cmd.op = OP_DIFF;
        if (sts.rd_w_zero) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_J_CHK;
        end else begin
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        cmd.op    = OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = OP_SQY;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op    = OP_SQRT;
        state_nxt = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (sts.sqrt_done) begin
          cmd.op    = OP_DIST;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.near) begin
          state_nxt = S_MUL;
        end else if (sts.d_zero) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_J_CHK;
        end else begin
          state_nxt = S_DQ;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_MRG;
      end
      S_MRG: begin
        cmd.op    = OP_MERGE;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_J_CHK;
      end
      S_DQ: begin
        cmd.op    = OP_DIV_Q;
        state_nxt = S_DQ_W;
      end
      S_DQ_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_LAT_Q;
          state_nxt = S_DA;
        end
      end
      S_DA: begin
        cmd.op    = OP_DIV_A;
        state_nxt = S_DA_W;
      end
      S_DA_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_LAT_A;
          state_nxt = S_DUX;
        end
      end
      S_DUX: begin
        cmd.op    = OP_DIV_UX;
        state_nxt = S_DUX_W;
      end
      S_DUX_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_LAT_U;
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        cmd.op    = OP_MULC;
        state_nxt = S_AX;
      end
      S_AX: begin
        cmd.op    = OP_ACC_X;
        state_nxt = S_DUY;
      end
      S_DUY: begin
        cmd.op    = OP_DIV_UY;
        state_nxt = S_DUY_W;
      end
      S_DUY_W: begin
        if (sts.div_done) begin
          cmd.op    = OP_LAT_U;
          state_nxt = S_MY;
        end
      end
      S_MY: begin
        cmd.op    = OP_MULC;
        state_nxt = S_AY;
      end
      S_AY: begin
        cmd.op    = OP_ACC_Y;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_J_CHK;
      end
      S_WB: begin
        cmd.op    = OP_WB;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_I_CHK;
      end
      S_P_CHK: begin
        if (i_r >= end_r) begin
          state_nxt = S_RES_ST;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_P_LAT;
        end
      end
      S_P_LAT: begin
        cmd.op = OP_LAT_I;
        if (sts.rd_w_zero) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_P_CHK;
        end else begin
          state_nxt = S_P_WR;
        end
      end
      S_P_WR: begin
        cmd.op    = OP_POS;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_P_CHK;
      end
      S_RES_ST: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT_ST;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      end_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      end_r   <= end_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

[src/nbody_gravity_step_absorb_top.sv]
// ----------------------------------------------------------------------------
// nbody_gravity_step_absorb_top: direct-sum 2-D gravity step with merging
// Body store of MAX_POINTS entries and a sequenced Q16.16 pair datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on the in_ channel (valid/ready) and carry a load, read or
//   step function. Results leave on the out_ channel (valid/ready). The
//   registers are written through cfg_we/cfg_index/cfg_wdata while idle.
//   A load gives no result and leaves the block idle. A read latches the
//   body into the read registers and then, once the result register is
//   free, into that register. A step walks every live slice body against
//   every live partner; a far pair is bound by the single bit-serial
//   divider (four divisions) and the bit-serial square root, while a
//   merging or skipped partner costs far less; one item is worked on at
//   a time.
//   Reset clears the controller, the result register and the registers
//   (threshold 1.0); body memories are not cleared, and an entry reads as
//   garbage until a load writes it. If the receiver stalls, the result
//   stays in the output register and the next item waits only for that
//   register to free before delivering its own result.
// ----------------------------------------------------------------------------
module nbody_gravity_step_absorb_top #(
  parameter int MAX_POINTS = nbgs_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nbgs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nbgs_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_wdata
);
  import nbgs_pkg::*;

  logic [8:0]  point_count_r;
  logic [7:0]  slice_start_r;
  logic [8:0]  slice_count_r;
  logic [30:0] dist_thr_r;

  cmd_t                          cmd;
  sts_t                          sts;
  logic [$clog2(MAX_POINTS)-1:0] addr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
      slice_start_r <= '0;
      slice_count_r <= '0;
      dist_thr_r    <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT: point_count_r <= cfg_wdata[8:0];
        REG_SLICE_START: slice_start_r <= cfg_wdata[7:0];
        REG_SLICE_COUNT: slice_count_r <= cfg_wdata[8:0];
        REG_DIST_THR:    dist_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  nbgs_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_func     (in_data.func),
    .point_count (point_count_r),
    .slice_start (slice_start_r),
    .slice_count (slice_count_r),
    .sts         (sts),
    .cmd         (cmd),
    .addr        (addr)
  );

  nbgs_dpath #(.MAX_POINTS(MAX_POINTS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .addr      (addr),
    .in_item   (in_data),
    .thr       (dist_thr_r),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  // A step or a read occupies the block for at least the next cycle.
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == FUNC_STEP |=> !in_ready)
    else $error("step accepted but block still ready");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == FUNC_READ |=> !in_ready)
    else $error("read accepted but block still ready");

  // A load completes in the cycle it is accepted.
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == FUNC_LOAD |=> in_ready)
    else $error("load did not return to idle");

  // A new result is only produced from a busy cycle.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

[verif/nbody_gravity_step_absorb_top_tb.sv]
// ----------------------------------------------------------------------------
// nbody_gravity_step_absorb_top_tb: self-checking bench for the gravity step
// Fills the whole body store and then walks a table of directed items.
// Random loads, steps and reads follow in four phases, each with its own
// register setting and its own pattern of sender gaps and receiver stalls.
// Every result is compared field by field with a Q16.16 model of the
// body store that is kept inside the bench.
// ----------------------------------------------------------------------------
module nbody_gravity_step_absorb_top_tb;
  import nbgs_pkg::*;

  localparam int NB = 256;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_wdata;

  nbody_gravity_step_absorb_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench copy of the body store and the registers.
  longint          pos_x [NB];
  longint          pos_y [NB];
  longint unsigned mass  [NB];
  longint          vel_x [NB];
  longint          vel_y [NB];
  int unsigned     n_active;
  int unsigned     upd_first;
  int unsigned     upd_count;
  logic [63:0]     merge_dist;

  out_item_t pending_results[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } row_t;
  row_t directed[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Bitwise search for the integer square root.
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] mass_product(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = (a * b) >> 16;
    return (p > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : p;
  endfunction

  function automatic longint axis_pull(input logic [63:0] mag, input bit neg,
                                       input logic [63:0] d, input logic [63:0] acc);
    logic [63:0] u;
    logic [63:0] c;
    u = (mag << 16) / d;
    if (u > 64'h2_0000) u = 64'h2_0000;
    c = (u * acc) >> 16;
    return neg ? -longint'(c) : longint'(c);
  endfunction

  // One body pair: either a merge or a contribution to the acceleration.
  task automatic pair_pull(input int i, input int j, inout longint ax, inout longint ay);
    longint      dx;
    longint      dy;
    logic [63:0] adx;
    logic [63:0] ady;
    logic [63:0] d;
    logic [63:0] q;
    logic [63:0] acc;
    int          s;
    dx  = pos_x[j] - pos_x[i];
    dy  = pos_y[j] - pos_y[i];
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    s   = (adx >= 64'h8000_0000 || ady >= 64'h8000_0000) ? 2 : 0;
    d   = root_floor((adx >> s) * (adx >> s) + (ady >> s) * (ady >> s)) << s;
    if (d < merge_dist) begin
      if (mass[i] > mass[j] || (mass[i] == mass[j] && i < j)) begin
        mass[i] = mass_product(mass[i], mass[j]);
        mass[j] = 0;
      end else begin
        mass[j] = mass_product(mass[j], mass[i]);
        mass[i] = 0;
      end
      return;
    end
    if (d == 0) return;
    q   = (64'(mass[j]) << 16) / d;
    acc = (q << 16) / d;
    if (acc > 64'h7FFF_FFFF) acc = 64'h7FFF_FFFF;
    ax += axis_pull(adx, dx < 0, d, acc);
    ay += axis_pull(ady, dy < 0, d, acc);
  endtask

  task automatic gravity_step();
    int     n;
    int     last;
    longint ax;
    longint ay;
    n    = (n_active > NB) ? NB : n_active;
    last = ((upd_first + upd_count) > NB) ? NB : (upd_first + upd_count);
    for (int i = upd_first; i < last; i++) begin
      if (mass[i] == 0) continue;
      ax = 0;
      ay = 0;
      for (int j = 0; j < n; j++) begin
        if (j == i || mass[j] == 0) continue;
        pair_pull(i, j, ax, ay);
      end
      vel_x[i] = clamp32(vel_x[i] + ax);
      vel_y[i] = clamp32(vel_y[i] + ay);
    end
    for (int i = upd_first; i < last; i++) begin
      if (mass[i] == 0) continue;
      pos_x[i] = clamp32(pos_x[i] + vel_x[i]);
      pos_y[i] = clamp32(pos_y[i] + vel_y[i]);
    end
  endtask

  // Apply one accepted item; returns 1 with the result if it causes one.
  task automatic apply_item(input in_item_t it, output bit got, output out_item_t res);
    int k;
    k   = it.body_index;
    got = 1'b0;
    res = '0;
    case (it.func)
      FUNC_LOAD: begin
        pos_x[k] = longint'(it.in_x);
        pos_y[k] = longint'(it.in_y);
        mass[k]  = it.in_weight;
        vel_x[k] = 0;
        vel_y[k] = 0;
      end
      FUNC_STEP: begin
        gravity_step();
        res.kind = KIND_STEP;
        got = 1'b1;
      end
      FUNC_READ: begin
        res.kind       = KIND_READ;
        res.out_index  = it.body_index;
        res.out_x      = pos_x[k][31:0];
        res.out_y      = pos_y[k][31:0];
        res.out_weight = mass[k][30:0];
        got = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t mk(input logic [1:0] f, input logic [7:0] idx,
                                  input logic [31:0] x, input logic [31:0] y,
                                  input logic [30:0] w);
    in_item_t it;
    it.func = f; it.body_index = idx; it.in_x = x; it.in_y = y; it.in_weight = w;
    return it;
  endfunction

  function automatic out_item_t rd_res(input logic [7:0] idx, input logic [31:0] x,
                                       input logic [31:0] y, input logic [30:0] w);
    out_item_t r;
    r.kind = KIND_READ; r.out_index = idx; r.out_x = x; r.out_y = y; r.out_weight = w;
    return r;
  endfunction

  // Send one item, honouring the sender gap rate, and record its result.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    bit        rdy;
    bit        got;
    out_item_t res;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    apply_item(it, got, res);
    if (got) pending_results.push_back(typed ? want : res);
  endtask

  // Stop sending and let every outstanding result drain, plus some margin.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_regs(input int unsigned pc, input int unsigned ss,
                            input int unsigned sc, input logic [30:0] thr);
    logic [30:0] vals [4];
    vals[REG_POINT_COUNT] = 31'(pc);
    vals[REG_SLICE_START] = 31'(ss);
    vals[REG_SLICE_COUNT] = 31'(sc);
    vals[REG_DIST_THR]    = thr;
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= r[1:0];
      cfg_wdata <= vals[r];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_active   = pc & 9'h1FF;
    upd_first  = ss & 8'hFF;
    upd_count  = sc & 9'h1FF;
    merge_dist = 64'(thr);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(99) < 85) return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    return $urandom;
  endfunction

  function automatic logic [30:0] rand_mass();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 31'($urandom_range(1, 32'h0010_0000));
    if (r < 90) return 31'($urandom);
    return '0;
  endfunction

  // Mostly live bodies in a small window, steps and reads; some noise.
  function automatic in_item_t rand_item();
    int r;
    r = $urandom_range(99);
    if (r < 20) return mk(FUNC_STEP, 8'($urandom), $urandom, $urandom, 31'($urandom));
    if (r < 55) return mk(FUNC_LOAD, 8'($urandom_range(0, 7)), rand_coord(), rand_coord(),
                          rand_mass());
    if (r < 65) return mk(FUNC_LOAD, 8'($urandom), rand_coord(), rand_coord(), '0);
    if (r < 92) return mk(FUNC_READ, 8'($urandom), $urandom, $urandom, 31'($urandom));
    return mk(2'd3, 8'($urandom), $urandom, $urandom, 31'($urandom));
  endfunction

  // Receiver: ready drops at the stall rate of the current phase.
  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Result check, sampled on the falling edge ahead of the accepting edge.
  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_data.kind);
          fail_count++;
        end
        if (out_data.out_index !== want.out_index) begin
          $display("%0t: index expected %0d actual %0d", $time, want.out_index,
                   out_data.out_index);
          fail_count++;
        end
        if (out_data.out_x !== want.out_x) begin
          $display("%0t: x expected %h actual %h", $time, want.out_x, out_data.out_x);
          fail_count++;
        end
        if (out_data.out_y !== want.out_y) begin
          $display("%0t: y expected %h actual %h", $time, want.out_y, out_data.out_y);
          fail_count++;
        end
        if (out_data.out_weight !== want.out_weight) begin
          $display("%0t: weight expected %h actual %h", $time, want.out_weight,
                   out_data.out_weight);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_item_t none;
    none      = '0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_POINT_COUNT;
    cfg_wdata = '0;
    for (int k = 0; k < NB; k++) begin
      pos_x[k] = 0; pos_y[k] = 0; mass[k] = 0; vel_x[k] = 0; vel_y[k] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Whole store written once, all bodies absorbed, so no read sees garbage.
    write_regs(NB, 0, NB, THR_RESET);
    for (int k = 0; k < NB; k++) send_item(mk(FUNC_LOAD, 8'(k), rand_coord(), rand_coord(),
                                              '0), 1'b0, none);

    // Directed items: extremes, a lone body, a tie merge, an absorbed body
    // that keeps merging while its own sum runs, and a far extreme pair.
    directed.push_back('{mk(FUNC_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, WMAX), 0, none});
    directed.push_back('{mk(FUNC_READ, 0, 0, 0, 0), 1,
                         rd_res(0, 32'h7FFF_FFFF, 32'h8000_0000, WMAX)});
    directed.push_back('{mk(FUNC_LOAD, 1, 0, 0, 0), 0, none});
    directed.push_back('{mk(FUNC_READ, 1, 0, 0, 0), 1, rd_res(1, 0, 0, 0)});
    directed.push_back('{mk(2'd3, 9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, WMAX), 0, none});
    directed.push_back('{mk(FUNC_STEP, 0, 0, 0, 0), 1, '{KIND_STEP, 0, 0, 0, 0}});
    directed.push_back('{mk(FUNC_READ, 0, 0, 0, 0), 1,
                         rd_res(0, 32'h7FFF_FFFF, 32'h8000_0000, WMAX)});
    directed.push_back('{mk(FUNC_LOAD, 8, 32'h8000_0000, 32'h7FFF_FFFF, ONE), 0, none});
    directed.push_back('{mk(FUNC_LOAD, 2, ONE, 0, ONE), 0, none});
    directed.push_back('{mk(FUNC_LOAD, 3, ONE + ONE / 2, 0, ONE), 0, none});
    directed.push_back('{mk(FUNC_LOAD, 4, 0, 100 * ONE, 2 * ONE), 0, none});
    directed.push_back('{mk(FUNC_LOAD, 5, 50 * ONE, 50 * ONE, ONE), 0, none});
    directed.push_back('{mk(FUNC_LOAD, 6, 50 * ONE + ONE / 2, 50 * ONE, 4 * ONE), 0, none});
    directed.push_back('{mk(FUNC_LOAD, 7, 50 * ONE + ONE / 5, 50 * ONE, ONE), 0, none});
    directed.push_back('{mk(FUNC_STEP, 0, 0, 0, 0), 0, none});
    for (int k = 0; k <= 8; k++) directed.push_back('{mk(FUNC_READ, 8'(k), 0, 0, 0), 0, none});
    directed.push_back('{mk(FUNC_LOAD, 0, 0, 0, 0), 0, none});
    directed.push_back('{mk(FUNC_LOAD, 8, 0, 0, 0), 0, none});
    foreach (directed[r]) send_item(directed[r].it, directed[r].typed, directed[r].want);

    // Random phases, each with its own setting and idling pattern.
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_regs(NB, 0, NB, THR_RESET); end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  write_regs(8, 0, 8, 0); end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; write_regs(0, 255, 1, WMAX); end
        default: begin
          send_idle_pct = 21; recv_stall_pct = 21;
          write_regs(511, 4, 511, 31'($urandom_range(0, 4 * ONE)));
        end
      endcase
      // Coincident bodies with a zero merge distance neither merge nor pull.
      if (p == 1) begin
        send_item(mk(FUNC_LOAD, 2, 3 * ONE, -3 * ONE, ONE), 1'b0, none);
        send_item(mk(FUNC_LOAD, 3, 3 * ONE, -3 * ONE, 2 * ONE), 1'b0, none);
        send_item(mk(FUNC_STEP, 0, 0, 0, 0), 1'b0, none);
        send_item(mk(FUNC_READ, 2, 0, 0, 0), 1'b0, none);
        send_item(mk(FUNC_READ, 3, 0, 0, 0), 1'b0, none);
      end
      for (int n = 0; n < 25; n++) begin
        if (p == 2 && n == 12) drain();
        send_item(rand_item(), 1'b0, none);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/nbgs_pkg.sv
src/nbgs_div.sv
src/nbgs_isqrt.sv
src/nbgs_dpath.sv
src/nbgs_ctrl.sv
src/nbody_gravity_step_absorb_top.sv
verif/nbody_gravity_step_absorb_top_tb.sv
